// ===== rtl/core/fjsve_pkg.sv =====
package fjsve_pkg;

   // Width of the value counter; it saturates at all ones.
   localparam int INDEX_BITS = 16;
   localparam int INDEX_OUT_BITS = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_CLOSE   = 2'd1,
      KIND_ABANDON = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  value_byte;
      logic [INDEX_OUT_BITS-1:0]   value_index;
      logic                        last;
   } result_type;

   // One queue entry holds every result that a single input byte causes.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

// ===== rtl/core/fjsve_front.sv =====
module fjsve_front
   import fjsve_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   typedef enum logic [4:0] {
      PH_SCAN        = 5'b00001,
      PH_KEY         = 5'b00010,
      PH_AFTER_KEY   = 5'b00100,
      PH_AFTER_COLON = 5'b01000,
      PH_VALUE       = 5'b10000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            prev_ff, prev_in;
   logic                  esc_ff, esc_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;

   logic       accept;
   logic       ends;
   logic       emit;
   result_type emit_res;
   logic       prev_is_bslash;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;
   assign ends = req_end_of_text || (req_text_byte == CH_NUL);
   assign prev_is_bslash = (prev_ff == CH_BSLASH);

   always_comb begin
      phase_in = phase_ff;
      prev_in = prev_ff;
      esc_in = esc_ff;
      count_in = count_ff;
      emit = 1'b0;
      emit_res.kind = KIND_BYTE;
      emit_res.value_byte = req_text_byte;
      emit_res.value_index = INDEX_OUT_BITS'(count_ff);
      emit_res.last = 1'b0;

      if (req_text_byte != CH_NUL) begin
         prev_in = req_text_byte;
         unique case (phase_ff)
            PH_KEY: begin
               if (req_text_byte == CH_QUOTE && !prev_is_bslash) begin
                  phase_in = PH_AFTER_KEY;
               end
            end
            PH_AFTER_KEY: begin
               if (!is_space(req_text_byte)) begin
                  if (req_text_byte == CH_COLON) begin
                     phase_in = PH_AFTER_COLON;
                  end else if (req_text_byte == CH_QUOTE) begin
                     phase_in = PH_KEY;
                  end else begin
                     phase_in = PH_SCAN;
                  end
               end
            end
            PH_AFTER_COLON: begin
               if (!is_space(req_text_byte)) begin
                  if (req_text_byte == CH_QUOTE) begin
                     phase_in = PH_VALUE;
                     esc_in = 1'b0;
                  end else begin
                     phase_in = PH_SCAN;
                  end
               end
            end
            PH_VALUE: begin
               if (esc_ff) begin
                  emit = 1'b1;
                  if (req_text_byte == CH_LOWER_N) begin
                     emit_res.value_byte = CH_LF;
                  end else if (req_text_byte == CH_LOWER_R) begin
                     emit_res.value_byte = CH_CR;
                  end
                  esc_in = 1'b0;
               end else if (req_text_byte == CH_QUOTE && !prev_is_bslash) begin
                  emit = 1'b1;
                  emit_res.kind = KIND_CLOSE;
                  emit_res.value_byte = 8'h00;
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
                  phase_in = PH_SCAN;
               end else if (req_text_byte == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            default: begin
               phase_in = (req_text_byte == CH_QUOTE) ? PH_KEY : PH_SCAN;
            end
         endcase
      end

      push_entry.two = 1'b0;
      push_entry.first = emit_res;
      push_entry.first.last = 1'b1;
      push_entry.second.kind = KIND_DONE;
      push_entry.second.value_byte = 8'h00;
      push_entry.second.value_index = INDEX_OUT_BITS'(count_in);
      push_entry.second.last = 1'b1;
      push = accept && emit;

      if (ends) begin
         push = accept;
         if (phase_in == PH_VALUE) begin
            // The open value is dropped along with any byte of this beat.
            push_entry.two = 1'b1;
            push_entry.first.kind = KIND_ABANDON;
            push_entry.first.value_byte = 8'h00;
            push_entry.first.value_index = INDEX_OUT_BITS'(count_in);
            push_entry.first.last = 1'b0;
         end else if (emit) begin
            push_entry.two = 1'b1;
            push_entry.first.last = 1'b0;
         end else begin
            push_entry.first = push_entry.second;
         end
         phase_in = PH_SCAN;
         prev_in = 8'h00;
         esc_in = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SCAN;
         prev_ff <= 8'h00;
         esc_ff <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         prev_ff <= prev_in;
         esc_ff <= esc_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/fjsve_queue.sv =====
module fjsve_queue
   import fjsve_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   entry_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      do_pop;

   assign full = (cnt_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/fjsve_back.sv =====
module fjsve_back
   import fjsve_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  entry_type                 head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_value_byte,
   output logic [INDEX_OUT_BITS-1:0] rsp_value_index,
   output logic                      rsp_last
);

   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   result_type res_ff, res_in;
   logic       load;

   // The output register may take a new beat when empty or being taken.
   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      sel_in = sel_ff;
      res_in = res_ff;
      pop = 1'b0;
      if (load) begin
         valid_in = !queue_empty;
         if (!queue_empty) begin
            res_in = sel_ff ? head.second : head.first;
            if (sel_ff || !head.two) begin
               pop = 1'b1;
               sel_in = 1'b0;
            end else begin
               sel_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = res_ff.kind;
   assign rsp_value_byte = res_ff.value_byte;
   assign rsp_value_index = res_ff.value_index;
   assign rsp_last = res_ff.last;

endmodule

// ===== rtl/core/flat_json_string_value_extractor.sv =====
// A result beat is written into the queue and then into the output register before it is
// valid; a stall at the output can hold it in the queue.
// Throughput: one input byte per cycle while the queue is not full; the parser updates its phase on each accepted byte.
// A byte that ends the text inside a value, or that closes a value and ends the text, yields two beats,
// and the output side then sends them one after the other, absorbed by a four-entry queue.
// Reset (synchronous, active high) returns the parser to scanning and empties the queue.
module flat_json_string_value_extractor
   import fjsve_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_text_byte,
   input  logic                      req_end_of_text,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_value_byte,
   output logic [INDEX_OUT_BITS-1:0] rsp_value_index,
   output logic                      rsp_last
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   fjsve_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   fjsve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   fjsve_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_value_index (rsp_value_index),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/flat_json_string_value_extractor_tb.sv =====
module flat_json_string_value_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fjsve_pkg::*;

   typedef enum logic [2:0] {
      PHASE_SCAN        = 3'd0,
      PHASE_KEY         = 3'd1,
      PHASE_AFTER_KEY   = 3'd2,
      PHASE_AFTER_COLON = 3'd3,
      PHASE_VALUE       = 3'd4
   } parse_phase_type;

   typedef enum int {
      TERM_END_FLAG,
      TERM_NUL,
      TERM_NUL_FLAGGED,
      TERM_CUT
   } text_term_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_beat_type;

   localparam int LONG_HOLD_CYCLES = 50;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_text_byte = 8'h00;
   logic                      req_end_of_text = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_value_byte;
   logic [INDEX_OUT_BITS-1:0] rsp_value_index;
   logic                      rsp_last;

   flat_json_string_value_extractor i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_value_index (rsp_value_index),
      .rsp_last        (rsp_last)
   );

   text_beat_type   pending_text[$];
   logic [7:0]      draft[$];
   result_type      predicted_beats[$];

   parse_phase_type phase = PHASE_SCAN;
   logic [7:0]      prev_byte = 8'h00;
   logic            escape_open = 1'b0;
   logic [INDEX_BITS-1:0] values_closed = '0;

   logic            req_fire = 1'b0;
   logic            rsp_fire = 1'b0;
   int unsigned     error_count = 0;
   int unsigned     beats_seen = 0;
   int unsigned     beats_taken = 0;
   int unsigned     send_gap = 0;
   int unsigned     take_gap = 0;
   int unsigned     hold_left = 0;
   logic            send_calm = 1'b0;
   logic            take_calm = 1'b0;
   text_beat_type   next_beat;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic result_type beat_of(input kind_type k, input logic [7:0] v,
                                          input logic [INDEX_BITS-1:0] idx);
      result_type r;
      r.kind = k;
      r.value_byte = v;
      r.value_index = idx[INDEX_OUT_BITS-1:0];
      r.last = 1'b0;
      return r;
   endfunction

   // Advances the parser by one accepted byte and queues the beats it causes.
   task automatic parse_text_byte(input logic [7:0] b, input logic eot);
      result_type outs[2];
      int         n;
      logic       ends;
      logic [7:0] o;
      n = 0;
      ends = eot || (b == CH_NUL);
      if (b != CH_NUL) begin
         case (phase)
            PHASE_KEY: begin
               if (b == CH_QUOTE && prev_byte != CH_BSLASH) phase = PHASE_AFTER_KEY;
            end
            PHASE_AFTER_KEY: begin
               if (!is_blank(b)) begin
                  if (b == CH_COLON) phase = PHASE_AFTER_COLON;
                  else if (b == CH_QUOTE) phase = PHASE_KEY;
                  else phase = PHASE_SCAN;
               end
            end
            PHASE_AFTER_COLON: begin
               if (!is_blank(b)) begin
                  if (b == CH_QUOTE) begin
                     phase = PHASE_VALUE;
                     escape_open = 1'b0;
                  end else begin
                     phase = PHASE_SCAN;
                  end
               end
            end
            PHASE_VALUE: begin
               if (escape_open) begin
                  o = b;
                  if (b == CH_LOWER_N) o = CH_LF;
                  else if (b == CH_LOWER_R) o = CH_CR;
                  outs[n] = beat_of(KIND_BYTE, o, values_closed);
                  n++;
                  escape_open = 1'b0;
               end else if (b == CH_QUOTE && prev_byte != CH_BSLASH) begin
                  outs[n] = beat_of(KIND_CLOSE, 8'h00, values_closed);
                  n++;
                  if (values_closed != {INDEX_BITS{1'b1}}) values_closed++;
                  phase = PHASE_SCAN;
               end else if (b == CH_BSLASH) begin
                  escape_open = 1'b1;
               end else begin
                  outs[n] = beat_of(KIND_BYTE, b, values_closed);
                  n++;
               end
            end
            default: begin
               phase = (b == CH_QUOTE) ? PHASE_KEY : PHASE_SCAN;
            end
         endcase
         prev_byte = b;
      end
      if (ends) begin
         // Whatever was decoded on this byte is dropped with the open value.
         if (phase == PHASE_VALUE) begin
            n = 0;
            outs[n] = beat_of(KIND_ABANDON, 8'h00, values_closed);
            n++;
         end
         outs[n] = beat_of(KIND_DONE, 8'h00, values_closed);
         n++;
         phase = PHASE_SCAN;
         prev_byte = 8'h00;
         escape_open = 1'b0;
         values_closed = '0;
      end
      if (n > 0) outs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) predicted_beats.push_back(outs[i]);
   endtask

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      $display("mismatch at beat %0d: %s expected 0x%0h got 0x%0h",
               beats_seen, field, want, got);
      error_count++;
   endtask

   // Stimulus helpers.
   task automatic add_literal(input string s);
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
   endtask

   task automatic add_blanks();
      int count;
      count = $urandom_range(0, 2);
      repeat (count) begin
         if ($urandom_range(0, 1) == 0) draft.push_back(CH_SPACE);
         else draft.push_back(8'($urandom_range(CH_TAB, CH_CR)));
      end
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         c = 8'($urandom_range(1, 255));
      end else begin
         c = 8'($urandom_range(8'h20, 8'h7E));
         if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
      end
      return c;
   endfunction

   task automatic commit_draft(input text_term_type how);
      int cut;
      text_beat_type t;
      if (draft.size() == 0 && how != TERM_NUL) how = TERM_NUL_FLAGGED;
      cut = draft.size() - 1;
      if (how == TERM_CUT) cut = $urandom_range(0, draft.size() - 1);
      for (int i = 0; i <= cut; i++) begin
         t.text_byte = draft[i];
         t.end_of_text = (i == cut) && (how == TERM_END_FLAG || how == TERM_CUT);
         pending_text.push_back(t);
      end
      if (how == TERM_NUL || how == TERM_NUL_FLAGGED) begin
         t.text_byte = CH_NUL;
         t.end_of_text = (how == TERM_NUL_FLAGGED);
         pending_text.push_back(t);
      end
      draft.delete();
   endtask

   function automatic text_term_type pick_term();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return TERM_END_FLAG;
      if (r < 8) return TERM_NUL;
      if (r < 9) return TERM_NUL_FLAGGED;
      return TERM_CUT;
   endfunction

   // Driver: holds each beat until it is taken, then waits its drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_text.size() > 0) begin
            next_beat = pending_text.pop_front();
            req_valid <= 1'b1;
            req_text_byte <= next_beat.text_byte;
            req_end_of_text <= next_beat.end_of_text;
            if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall per beat, plus two long hold-offs that back up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) begin
            beats_taken++;
            if ($urandom_range(0, 39) == 0) take_calm = ~take_calm;
            take_gap = take_calm ? 0 : $urandom_range(0, 3);
            if (beats_taken == 60 || beats_taken == 300) hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (take_gap > 0) begin
            rsp_stall <= 1'b1;
            take_gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predicts on every accepted byte and checks every accepted result beat.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) parse_text_byte(req_text_byte, req_end_of_text);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_beats.size() == 0) begin
               report("unexpected beat, kind", 0, rsp_kind);
            end else begin
               if (rsp_kind !== predicted_beats[0].kind)
                  report("kind", predicted_beats[0].kind, rsp_kind);
               if (rsp_value_byte !== predicted_beats[0].value_byte)
                  report("value_byte", predicted_beats[0].value_byte, rsp_value_byte);
               if (rsp_value_index !== predicted_beats[0].value_index)
                  report("value_index", predicted_beats[0].value_index, rsp_value_index);
               if (rsp_last !== predicted_beats[0].last)
                  report("last", predicted_beats[0].last, rsp_last);
               void'(predicted_beats.pop_front());
            end
            beats_seen++;
         end
      end
   end

   initial begin : stimulus
      int pairs;
      int len;
      int r;
      // Directed: whitespace after key and colon, raw 0xFF, escapes, a quote after an
      // escaped backslash that does not close, and a closing quote that ends the text.
      add_literal("\"a\"\t: \"");
      draft.push_back(8'hFF);
      add_literal("\\n\\\\\"\"");
      commit_draft(TERM_END_FLAG);
      // A quote after a key opens a new key, a non-quote after a colon returns to
      // scanning, and the text ends with a backslash pending in a value.
      add_literal("\"b\"\"c\":1\"d\":\"\\");
      commit_draft(TERM_END_FLAG);
      // Another byte after a key returns to scanning; a zero byte ends an open value.
      add_literal("\"e\"x\"f\":\"");
      commit_draft(TERM_NUL);
      // Empty text.
      commit_draft(TERM_NUL_FLAGGED);

      while (pending_text.size() < 740) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            draft.push_back(8'h7B);
            add_blanks();
            pairs = $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++) begin
               if (p > 0) begin
                  draft.push_back(8'h2C);
                  add_blanks();
               end
               draft.push_back(CH_QUOTE);
               len = $urandom_range(1, 4);
               repeat (len) begin
                  if ($urandom_range(0, 7) == 0) draft.push_back(CH_BSLASH);
                  draft.push_back(($urandom_range(0, 7) == 0) ? CH_QUOTE : text_char());
               end
               draft.push_back(CH_QUOTE);
               add_blanks();
               draft.push_back(CH_COLON);
               add_blanks();
               draft.push_back(CH_QUOTE);
               len = $urandom_range(0, 8);
               repeat (len) begin
                  case ($urandom_range(0, 9))
                     6: begin
                        draft.push_back(CH_BSLASH);
                        draft.push_back(CH_LOWER_N);
                     end
                     7: begin
                        draft.push_back(CH_BSLASH);
                        draft.push_back(CH_LOWER_R);
                     end
                     8: begin
                        draft.push_back(CH_BSLASH);
                        draft.push_back(($urandom_range(0, 1) == 0) ? CH_QUOTE : CH_BSLASH);
                     end
                     9: begin
                        draft.push_back(CH_BSLASH);
                        draft.push_back(8'($urandom_range(1, 255)));
                     end
                     default: draft.push_back(text_char());
                  endcase
               end
               draft.push_back(CH_QUOTE);
               add_blanks();
            end
            draft.push_back(8'h7D);
            commit_draft(pick_term());
         end else begin
            // Noise, rich in the bytes that steer the parser.
            len = $urandom_range(1, 12);
            repeat (len) begin
               case ($urandom_range(0, 5))
                  0: draft.push_back(CH_QUOTE);
                  1: draft.push_back(CH_COLON);
                  2: draft.push_back(CH_BSLASH);
                  3: draft.push_back(CH_SPACE);
                  default: draft.push_back(8'($urandom_range(1, 255)));
               endcase
            end
            commit_draft(pick_term());
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_text.size() != 0 || req_valid) @(posedge clock);
      while (predicted_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== flat_json_string_value_extractor.f =====
rtl/core/fjsve_pkg.sv
rtl/core/fjsve_front.sv
rtl/core/fjsve_queue.sv
rtl/core/fjsve_back.sv
rtl/core/flat_json_string_value_extractor.sv
tb/flat_json_string_value_extractor_tb.sv
